// ----- hw/rtl/pfu_pkg.sv -----
package pfu_pkg;

  // Ring geometry
  localparam int CAP     = 1024;
  localparam int AW      = $clog2(CAP);
  localparam int CW      = AW + 1;
  localparam int FW      = 64;
  localparam int MAX_REQ = 64;
  localparam int NW      = 7;
  localparam int BW      = 4;
  localparam int GW      = 32;
  localparam int NUM_CNT = 9;
  localparam int SW      = 4;

  // Statistics counter indexes
  localparam int CNT_SUBMITTED = 0;
  localparam int CNT_CONSUMED  = 1;
  localparam int CNT_OVERFLOW  = 2;
  localparam int CNT_DROP_FRM  = 3;
  localparam int CNT_DROP_BYTE = 4;
  localparam int CNT_UNDERRUN  = 5;
  localparam int CNT_SILENCE   = 6;
  localparam int CNT_CLR_FRM   = 7;
  localparam int CNT_CLR_EVT   = 8;

  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_READ   = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_RSTCNT = 2'd3
  } kind_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  // Counter update request from the control path to the statistics block
  typedef struct packed {
    logic                        clr;
    logic [NUM_CNT-1:0][CW-1:0]  add;
  } stat_upd_t;

  // Keep the low b bytes of a frame
  function automatic logic [FW-1:0] byte_mask(input logic [BW-1:0] b);
    logic [FW-1:0] m;
    m = '0;
    for (int i = 0; i < FW / 8; i++) begin
      m[i*8 +: 8] = (b > BW'(i)) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

// ----- hw/rtl/pfu_in_if.sv -----
interface pfu_in_if;
  import pfu_pkg::*;

  logic          valid;
  logic          ready;
  logic [1:0]    kind;
  logic [FW-1:0] in_frame;
  logic [NW-1:0] frame_count;
  logic          burst_last;
  logic          check_generation;
  logic [GW-1:0] generation_tag;
  logic [SW-1:0] counter_select;

  modport source (
    output valid, kind, in_frame, frame_count, burst_last,
           check_generation, generation_tag, counter_select,
    input  ready
  );

  modport sink (
    input  valid, kind, in_frame, frame_count, burst_last,
           check_generation, generation_tag, counter_select,
    output ready
  );
endinterface

// ----- hw/rtl/pfu_out_if.sv -----
interface pfu_out_if;
  import pfu_pkg::*;

  logic          valid;
  logic          ready;
  logic [FW-1:0] out_frame;
  logic          frame_silent;
  logic          last;
  logic          write_accepted;
  logic [NW-1:0] copied_frames;
  logic [NW-1:0] silence_frames;
  logic [CW-1:0] available_frames;
  logic [GW-1:0] current_generation;
  logic [GW-1:0] counter_value;

  modport source (
    output valid, out_frame, frame_silent, last, write_accepted, copied_frames,
           silence_frames, available_frames, current_generation, counter_value,
    input  ready
  );

  modport sink (
    input  valid, out_frame, frame_silent, last, write_accepted, copied_frames,
           silence_frames, available_frames, current_generation, counter_value,
    output ready
  );
endinterface

// ----- hw/rtl/pfu_frame_ram.sv -----
module pfu_frame_ram (
  input  logic                   clk,
  input  logic                   we,
  input  logic [pfu_pkg::AW-1:0] waddr,
  input  logic [pfu_pkg::FW-1:0] wdata,
  input  logic                   re,
  input  logic [pfu_pkg::AW-1:0] raddr,
  output logic [pfu_pkg::FW-1:0] rdata
);
  import pfu_pkg::*;

  logic [FW-1:0] mem [CAP];
  logic [FW-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port: data holds while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

// ----- hw/rtl/pfu_stats.sv -----
module pfu_stats (
  input  logic                   clk,
  input  logic                   rst_n,
  input  pfu_pkg::stat_upd_t     upd,
  input  logic [pfu_pkg::SW-1:0] sel,
  output logic [pfu_pkg::GW-1:0] value
);
  import pfu_pkg::*;

  logic [GW-1:0] cnt_r [NUM_CNT];

  // Event counters, wrapping
  always_ff @(posedge clk) begin
    if (!rst_n || upd.clr) begin
      for (int i = 0; i < NUM_CNT; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_CNT; i++) begin
        cnt_r[i] <= cnt_r[i] + GW'(upd.add[i]);
      end
    end
  end

  // Report mux, unused selects read zero
  always_comb begin
    value = '0;
    for (int i = 0; i < NUM_CNT; i++) begin
      if (sel == SW'(i)) begin
        value = cnt_r[i];
      end
    end
  end
endmodule

// ----- hw/rtl/pcm_frame_fifo_underrun_fill.sv -----
// PCM frame ring FIFO with silence fill on underrun.
// in_ch carries items: write beats, read requests, clear-for-seek and
// counter reset. out_ch carries result items. cfg_we/cfg_wdata set the
// frame size in bytes (reset value 4); it must be written only while idle,
// which the block does not enforce. Write beats are taken one per cycle
// while idle with the output free; a burst is accepted or dropped on its
// first beat and commits on the beat marked burst_last, which gives one
// result. Other beats give no result. A read request of N frames gives N
// results, one per cycle while the receiver takes them; the frame store
// is a single-port read synchronous RAM and the read sequencer issues one
// address a cycle unless stalled; no new item is taken until the read has
// ended. Clear, counter reset and zero-length reads give a status result.
// Reset empties the queue and clears cursors, generation and counters;
// the frame store itself is not cleared and needs no clearing pass.
// When the receiver stalls, the output register holds its item and the
// read sequencer keeps one prefetched frame; nothing is lost, and no new
// item is taken until the pending result has gone.
module pcm_frame_fifo_underrun_fill (
  input  logic                   clk,
  input  logic                   rst_n,
  pfu_in_if.sink                 in_ch,
  pfu_out_if.source              out_ch,
  input  logic                   cfg_we,
  input  logic [pfu_pkg::BW-1:0] cfg_wdata
);
  import pfu_pkg::*;

  // Control state
  state_t        state_r, state_nxt;
  logic [CW-1:0] wc_r, wc_nxt;
  logic [CW-1:0] rc_r, rc_nxt;
  logic [GW-1:0] gen_r, gen_nxt;
  logic [BW-1:0] bpf_r;
  logic          burst_open_r, burst_open_nxt;
  logic          burst_ok_r, burst_ok_nxt;
  logic [NW-1:0] burst_beats_r, burst_beats_nxt;
  logic [NW-1:0] burst_len_r, burst_len_nxt;
  logic [SW-1:0] sel_r, sel_nxt;
  logic [NW-1:0] iss_r, iss_nxt;
  logic          pend_r, pend_nxt;
  logic          out_valid_r, out_valid_nxt;

  // Read job and output payload
  logic [AW-1:0] rd_base_r, rd_base_nxt;
  logic [NW-1:0] rd_cnt_r, rd_cnt_nxt;
  logic [NW-1:0] rd_copied_r, rd_copied_nxt;
  logic [NW-1:0] rd_sil_r, rd_sil_nxt;
  logic          pend_sil_r, pend_sil_nxt;
  logic          pend_last_r, pend_last_nxt;
  logic [FW-1:0] o_frame_r, o_frame_nxt;
  logic          o_silent_r, o_silent_nxt;
  logic          o_last_r, o_last_nxt;
  logic          o_acc_r, o_acc_nxt;
  logic [NW-1:0] o_copied_r, o_copied_nxt;
  logic [NW-1:0] o_sil_r, o_sil_nxt;

  // Memory and stats hookups
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [FW-1:0] ram_wdata, ram_rdata;
  stat_upd_t     upd;
  logic [GW-1:0] cnt_value;

  // Derived values
  logic          in_acc, can_load;
  logic [CW-1:0] used;
  logic [NW-1:0] cnt_sat;
  logic [BW-1:0] eff_b;
  logic          fits, stale;
  logic [NW-1:0] rq_copied, rq_sil;
  logic          w_first, w_ok, w_store;
  logic [NW-1:0] w_len, w_beats, w_beats_n;
  logic [CW-1:0] w_pos;
  logic          issue;
  kind_t         kind;

  assign kind     = kind_t'(in_ch.kind);
  assign can_load = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) && can_load;
  assign in_acc   = in_ch.valid && in_ch.ready;

  assign used    = wc_r - rc_r;
  assign cnt_sat = (in_ch.frame_count > NW'(MAX_REQ)) ? NW'(MAX_REQ) : in_ch.frame_count;
  assign eff_b   = (bpf_r > BW'(8)) ? BW'(8) : bpf_r;
  assign fits    = ({1'b0, used} + (CW+1)'(cnt_sat)) <= (CW+1)'(CAP);
  assign stale   = in_ch.check_generation && (in_ch.generation_tag != gen_r);

  // Read split: stored frames first, silence for the rest
  always_comb begin
    rq_copied = '0;
    if (bpf_r != '0 && !stale) begin
      rq_copied = (CW'(cnt_sat) < used) ? cnt_sat : used[NW-1:0];
    end
    rq_sil = cnt_sat - rq_copied;
  end

  // Write burst bookkeeping
  assign w_first   = !burst_open_r;
  assign w_len     = w_first ? cnt_sat : burst_len_r;
  assign w_ok      = w_first ? (eff_b != '0 && fits) : burst_ok_r;
  assign w_beats   = w_first ? '0 : burst_beats_r;
  assign w_store   = w_ok && (w_beats < w_len);
  assign w_beats_n = w_beats + NW'(w_store);
  assign w_pos     = wc_r + CW'(w_beats);

  assign ram_we    = in_acc && kind == KIND_WRITE && w_store;
  assign ram_waddr = w_pos[AW-1:0];
  assign ram_wdata = in_ch.in_frame & byte_mask(eff_b);

  // Read sequencer address issue
  assign issue     = (state_r == ST_READ) && (iss_r < rd_cnt_r) && (!pend_r || can_load);
  assign ram_re    = issue && (iss_r < rd_copied_r);
  assign ram_raddr = rd_base_r + AW'(iss_r);

  // Next state and outputs
  always_comb begin
    state_nxt       = state_r;
    wc_nxt          = wc_r;
    rc_nxt          = rc_r;
    gen_nxt         = gen_r;
    burst_open_nxt  = burst_open_r;
    burst_ok_nxt    = burst_ok_r;
    burst_beats_nxt = burst_beats_r;
    burst_len_nxt   = burst_len_r;
    sel_nxt         = sel_r;
    iss_nxt         = iss_r;
    pend_nxt        = pend_r;
    pend_sil_nxt    = pend_sil_r;
    pend_last_nxt   = pend_last_r;
    rd_base_nxt     = rd_base_r;
    rd_cnt_nxt      = rd_cnt_r;
    rd_copied_nxt   = rd_copied_r;
    rd_sil_nxt      = rd_sil_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    o_frame_nxt     = o_frame_r;
    o_silent_nxt    = o_silent_r;
    o_last_nxt      = o_last_r;
    o_acc_nxt       = o_acc_r;
    o_copied_nxt    = o_copied_r;
    o_sil_nxt       = o_sil_r;
    upd             = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          sel_nxt      = in_ch.counter_select;
          // status result by default
          o_frame_nxt  = '0;
          o_silent_nxt = 1'b0;
          o_last_nxt   = 1'b1;
          o_acc_nxt    = 1'b0;
          o_copied_nxt = '0;
          o_sil_nxt    = '0;
          unique case (kind)
            KIND_WRITE: begin
              if (w_first && !w_ok) begin
                upd.add[CNT_OVERFLOW]  = CW'(1);
                upd.add[CNT_DROP_FRM]  = CW'(cnt_sat);
                upd.add[CNT_DROP_BYTE] = CW'(cnt_sat) * CW'(eff_b);
              end
              if (in_ch.burst_last) begin
                if (w_ok) begin
                  wc_nxt                 = wc_r + CW'(w_beats_n);
                  upd.add[CNT_SUBMITTED] = CW'(w_beats_n);
                end
                burst_open_nxt = 1'b0;
                o_acc_nxt      = w_ok;
                out_valid_nxt  = 1'b1;
              end else begin
                burst_open_nxt  = 1'b1;
                burst_ok_nxt    = w_ok;
                burst_len_nxt   = w_len;
                burst_beats_nxt = w_beats_n;
              end
            end
            KIND_READ: begin
              if (cnt_sat == '0) begin
                out_valid_nxt = 1'b1;
              end else begin
                state_nxt             = ST_READ;
                iss_nxt               = '0;
                pend_nxt              = 1'b0;
                rd_base_nxt           = rc_r[AW-1:0];
                rd_cnt_nxt            = cnt_sat;
                rd_copied_nxt         = rq_copied;
                rd_sil_nxt            = rq_sil;
                rc_nxt                = rc_r + CW'(rq_copied);
                upd.add[CNT_CONSUMED] = CW'(rq_copied);
                upd.add[CNT_SILENCE]  = CW'(rq_sil);
                upd.add[CNT_UNDERRUN] = CW'(rq_sil != '0);
              end
            end
            KIND_CLEAR: begin
              gen_nxt              = gen_r + GW'(1);
              rc_nxt               = wc_r;
              upd.add[CNT_CLR_EVT] = CW'(1);
              upd.add[CNT_CLR_FRM] = (bpf_r != '0) ? used : '0;
              out_valid_nxt        = 1'b1;
            end
            KIND_RSTCNT: begin
              upd.clr       = 1'b1;
              out_valid_nxt = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        // move the prefetched frame into the output register
        if (pend_r && can_load) begin
          o_frame_nxt   = pend_sil_r ? '0 : ram_rdata;
          o_silent_nxt  = pend_sil_r;
          o_last_nxt    = pend_last_r;
          o_acc_nxt     = 1'b0;
          o_copied_nxt  = rd_copied_r;
          o_sil_nxt     = rd_sil_r;
          out_valid_nxt = 1'b1;
          pend_nxt      = 1'b0;
          if (pend_last_r) begin
            state_nxt = ST_IDLE;
          end
        end
        // fetch the next frame
        if (issue) begin
          pend_nxt      = 1'b1;
          pend_sil_nxt  = !(iss_r < rd_copied_r);
          pend_last_nxt = (iss_r + NW'(1)) == rd_cnt_r;
          iss_nxt       = iss_r + NW'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      wc_r          <= '0;
      rc_r          <= '0;
      gen_r         <= '0;
      bpf_r         <= BW'(4);
      burst_open_r  <= 1'b0;
      burst_ok_r    <= 1'b0;
      burst_beats_r <= '0;
      burst_len_r   <= '0;
      sel_r         <= '0;
      iss_r         <= '0;
      pend_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      wc_r          <= wc_nxt;
      rc_r          <= rc_nxt;
      gen_r         <= gen_nxt;
      if (cfg_we) begin
        bpf_r <= cfg_wdata;
      end
      burst_open_r  <= burst_open_nxt;
      burst_ok_r    <= burst_ok_nxt;
      burst_beats_r <= burst_beats_nxt;
      burst_len_r   <= burst_len_nxt;
      sel_r         <= sel_nxt;
      iss_r         <= iss_nxt;
      pend_r        <= pend_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rd_base_r   <= rd_base_nxt;
    rd_cnt_r    <= rd_cnt_nxt;
    rd_copied_r <= rd_copied_nxt;
    rd_sil_r    <= rd_sil_nxt;
    pend_sil_r  <= pend_sil_nxt;
    pend_last_r <= pend_last_nxt;
    o_frame_r   <= o_frame_nxt;
    o_silent_r  <= o_silent_nxt;
    o_last_r    <= o_last_nxt;
    o_acc_r     <= o_acc_nxt;
    o_copied_r  <= o_copied_nxt;
    o_sil_r     <= o_sil_nxt;
  end

  pfu_frame_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pfu_stats u_stats (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (upd),
    .sel   (sel_r),
    .value (cnt_value)
  );

  // Result channel; status fields track live state, which only a frame-size
  // write can move while a result is still waiting
  assign out_ch.valid              = out_valid_r;
  assign out_ch.out_frame          = o_frame_r;
  assign out_ch.frame_silent       = o_silent_r;
  assign out_ch.last               = o_last_r;
  assign out_ch.write_accepted     = o_acc_r;
  assign out_ch.copied_frames      = o_copied_r;
  assign out_ch.silence_frames     = o_sil_r;
  assign out_ch.available_frames   = (bpf_r == '0) ? '0 : used;
  assign out_ch.current_generation = gen_r;
  assign out_ch.counter_value      = cnt_value;
endmodule

// ----- dv/pcm_frame_fifo_underrun_fill_tb.sv -----
`timescale 1ns / 100ps

module pcm_frame_fifo_underrun_fill_tb;
  import pfu_pkg::*;

  localparam int QUIET_LIMIT = 2000;

  // One input item as it goes onto in_ch
  typedef struct packed {
    kind_t         kind;
    logic [FW-1:0] frame;
    logic [NW-1:0] count;
    logic          last;
    logic          chk;
    logic [GW-1:0] tag;
    logic [SW-1:0] sel;
  } stim_t;

  // One result item as it comes off out_ch
  typedef struct packed {
    logic [FW-1:0] frame;
    logic          silent;
    logic          last;
    logic          acc;
    logic [NW-1:0] copied;
    logic [NW-1:0] silence;
    logic [CW-1:0] avail;
    logic [GW-1:0] gen;
    logic [GW-1:0] cval;
  } res_t;

  typedef struct {
    stim_t it;
    int    cfg;     // frame size to set first, -1 for none
    bit    typed;   // result typed in by hand
    res_t  res;
  } row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [BW-1:0] cfg_wdata;

  pfu_in_if  in_ch ();
  pfu_out_if out_ch ();

  pcm_frame_fifo_underrun_fill u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Ring model state
  logic [FW-1:0] m_store [CAP];
  logic [CW-1:0] m_wcur = '0;
  logic [CW-1:0] m_rcur = '0;
  logic [GW-1:0] m_gen  = '0;
  bit            m_open = 1'b0;
  bit            m_ok   = 1'b0;
  int unsigned   m_beats = 0;
  int unsigned   m_len   = 0;
  logic [31:0]   m_cnt [NUM_CNT];
  logic [BW-1:0] m_bpf  = BW'(4);

  res_t step_results [$];
  res_t queued_results [$];
  row_t dir_tab [$];

  int gap_pct   = 0;
  int stall_pct = 0;
  int n_err     = 0;
  int n_in      = 0;
  int n_out     = 0;
  int n_cfg     = 0;
  int quiet     = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned ring_used();
    logic [CW-1:0] d;
    d = m_wcur - m_rcur;
    return 32'(d);
  endfunction

  function automatic res_t mk_res(input logic [FW-1:0] f, input bit sil, input bit lst,
                                  input bit acc, input int unsigned cp,
                                  input int unsigned sl, input logic [SW-1:0] sel);
    res_t r;
    r.frame   = f;
    r.silent  = sil;
    r.last    = lst;
    r.acc     = acc;
    r.copied  = NW'(cp);
    r.silence = NW'(sl);
    r.avail   = (m_bpf == 0) ? '0 : CW'(ring_used());
    r.gen     = m_gen;
    r.cval    = (sel <= 8) ? m_cnt[sel] : '0;
    return r;
  endfunction

  // Advance the ring model by one item; results land in step_results
  function automatic void ring_step(input stim_t it);
    int unsigned   n, b, cp, sl, k, held;
    logic [FW-1:0] keep, f;
    logic [CW-1:0] start;
    bit            stale;
    n = (it.count > MAX_REQ) ? MAX_REQ : it.count;
    b = (m_bpf > 8) ? 8 : m_bpf;
    step_results = {};
    case (it.kind)
      KIND_WRITE: begin
        // accept or drop is decided on the opening beat
        if (!m_open) begin
          m_open  = 1'b1;
          m_len   = n;
          m_beats = 0;
          m_ok    = (b != 0) && (n <= CAP - ring_used());
          if (!m_ok) begin
            m_cnt[CNT_OVERFLOW]  += 1;
            m_cnt[CNT_DROP_FRM]  += n;
            m_cnt[CNT_DROP_BYTE] += n * b;
          end
        end
        if (m_ok && m_beats < m_len) begin
          keep = (b >= 8) ? '1 : ((64'd1 << (8 * b)) - 64'd1);
          m_store[AW'(m_wcur + m_beats)] = it.frame & keep;
          m_beats++;
        end
        if (it.last) begin
          if (m_ok) begin
            m_wcur = m_wcur + CW'(m_beats);
            m_cnt[CNT_SUBMITTED] += m_beats;
          end
          m_open = 1'b0;
          step_results.push_back(mk_res('0, 1'b0, 1'b1, m_ok, 0, 0, it.sel));
        end
      end
      KIND_READ: begin
        stale = it.chk && (it.tag != m_gen);
        if (n == 0) begin
          step_results.push_back(mk_res('0, 1'b0, 1'b1, 1'b0, 0, 0, it.sel));
        end else begin
          cp = 0;
          if (m_bpf != 0 && !stale) cp = (n < ring_used()) ? n : ring_used();
          sl = n - cp;
          if (sl > 0) m_cnt[CNT_UNDERRUN] += 1;
          m_cnt[CNT_CONSUMED] += cp;
          m_cnt[CNT_SILENCE]  += sl;
          start  = m_rcur;
          m_rcur = m_rcur + CW'(cp);
          for (k = 0; k < n; k++) begin
            f = (k < cp) ? m_store[AW'(start + k)] : '0;
            step_results.push_back(mk_res(f, k >= cp, k + 1 == n, 1'b0, cp, sl, it.sel));
          end
        end
      end
      KIND_CLEAR: begin
        held   = ring_used();
        m_gen  = m_gen + 1;
        m_rcur = m_wcur;
        m_cnt[CNT_CLR_EVT] += 1;
        if (m_bpf != 0) m_cnt[CNT_CLR_FRM] += held;
        step_results.push_back(mk_res('0, 1'b0, 1'b1, 1'b0, 0, 0, it.sel));
      end
      KIND_RSTCNT: begin
        foreach (m_cnt[i]) m_cnt[i] = '0;
        step_results.push_back(mk_res('0, 1'b0, 1'b1, 1'b0, 0, 0, it.sel));
      end
    endcase
  endfunction

  function automatic stim_t rand_stim(input kind_t k);
    stim_t s;
    s.kind  = k;
    s.frame = {$urandom, $urandom};
    s.count = NW'($urandom_range(127));
    s.last  = 1'($urandom_range(1));
    s.chk   = 1'($urandom_range(1));
    s.tag   = $urandom;
    s.sel   = SW'($urandom_range(15));
    return s;
  endfunction

  function automatic void add_row(input kind_t k, input logic [FW-1:0] f, input int cnt,
                                  input bit lst, input bit chk, input logic [GW-1:0] tag,
                                  input int sel, input int cfg = -1, input bit typed = 1'b0,
                                  input res_t r = '0);
    row_t row;
    row.it    = '{k, f, NW'(cnt), lst, chk, tag, SW'(sel)};
    row.cfg   = cfg;
    row.typed = typed;
    row.res   = r;
    dir_tab.push_back(row);
  endfunction

  // Directed items: extremes, every kind, and the corner cases of the ring
  function automatic void build_table();
    res_t r0, r1, r2;
    r0 = '{64'd0, 1'b0, 1'b1, 1'b0, 7'd0, 7'd0, 11'd0, 32'd0, 32'd0};
    r1 = '{64'd0, 1'b1, 1'b1, 1'b0, 7'd0, 7'd1, 11'd0, 32'd0, 32'd1};
    r2 = '{64'd0, 1'b0, 1'b1, 1'b0, 7'd0, 7'd0, 11'd0, 32'd1, 32'd1};
    // status read straight after reset, then a one-frame underrun
    add_row(KIND_READ, '0, 0, 0, 0, '0, CNT_CLR_EVT, -1, 1'b1, r0);
    add_row(KIND_READ, '0, 1, 0, 0, '0, CNT_UNDERRUN, -1, 1'b1, r1);
    // oversize read of an empty ring
    add_row(KIND_READ, '0, 127, 0, 0, '0, CNT_SILENCE);
    // three-beat burst, frames masked to four bytes
    add_row(KIND_WRITE, '1, 3, 0, 0, '0, 0);
    add_row(KIND_WRITE, '0, 0, 0, 0, '0, 0);
    add_row(KIND_WRITE, 64'h0123_4567_89AB_CDEF, 0, 1, 0, '0, CNT_SUBMITTED);
    // beats past the declared length are ignored
    add_row(KIND_WRITE, 64'hA5A5_A5A5_A5A5_A5A5, 1, 0, 0, '0, 0);
    add_row(KIND_WRITE, 64'h5A5A_5A5A_5A5A_5A5A, 0, 0, 0, '0, 0);
    add_row(KIND_WRITE, '1, 0, 1, 0, '0, CNT_SUBMITTED);
    // zero-length burst
    add_row(KIND_WRITE, '0, 0, 1, 0, '0, CNT_OVERFLOW);
    // short burst with a read and a seek while it is open
    add_row(KIND_WRITE, 64'hFEDC_BA98_7654_3210, 5, 0, 0, '0, 0);
    add_row(KIND_READ, '0, 2, 0, 0, '0, CNT_CONSUMED);
    add_row(KIND_CLEAR, '0, 0, 0, 0, '0, CNT_CLR_FRM);
    add_row(KIND_WRITE, 64'h1111_2222_3333_4444, 0, 1, 0, '0, CNT_SUBMITTED);
    // stale tag, then a matching tag with an out-of-range counter select
    add_row(KIND_READ, '0, 4, 0, 1, 32'hFFFF_FFFF, CNT_UNDERRUN);
    add_row(KIND_READ, '1, 4, 1, 1, 32'd1, 15);
    // oversize burst length, closed after two beats
    add_row(KIND_WRITE, 64'h8000_0000_0000_0001, 127, 0, 0, '0, 0);
    add_row(KIND_WRITE, 64'h7FFF_FFFF_FFFF_FFFE, 0, 1, 0, '0, CNT_SUBMITTED);
    add_row(KIND_RSTCNT, '0, 0, 0, 0, '0, CNT_SUBMITTED);
    // zero frame size: write dropped, read all silence, seek counts no frames
    add_row(KIND_WRITE, '1, 2, 1, 0, '0, CNT_OVERFLOW, 0, 1'b1, r2);
    add_row(KIND_READ, '0, 3, 0, 0, '0, CNT_UNDERRUN);
    add_row(KIND_CLEAR, '0, 0, 0, 0, '0, CNT_CLR_FRM);
    // frame size above eight acts as eight
    add_row(KIND_WRITE, '1, 1, 1, 0, '0, CNT_SUBMITTED, 15);
    add_row(KIND_READ, '0, 1, 0, 0, '0, CNT_CONSUMED);
    // one-byte frames, then a full-size read mostly silence
    add_row(KIND_WRITE, '1, 1, 1, 0, '0, CNT_DROP_BYTE, 1);
    add_row(KIND_READ, '0, 64, 0, 0, '0, CNT_SILENCE);
  endfunction

  function automatic void set_mode(input int m);
    case (m)
      0: begin gap_pct = 0;  stall_pct = 0;  end
      1: begin gap_pct = 66; stall_pct = 0;  end
      2: begin gap_pct = 0;  stall_pct = 66; end
      default: begin gap_pct = 34; stall_pct = 34; end
    endcase
  endfunction

  // Offer one item, wait for the handshake, then book its results
  task automatic send(input stim_t it, input bit typed = 1'b0, input res_t fixed = '0);
    while ($urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.kind             <= it.kind;
    in_ch.in_frame         <= it.frame;
    in_ch.frame_count      <= it.count;
    in_ch.burst_last       <= it.last;
    in_ch.check_generation <= it.chk;
    in_ch.generation_tag   <= it.tag;
    in_ch.counter_select   <= it.sel;
    do @(posedge clk); while (!in_ch.ready);
    n_in++;
    ring_step(it);
    if (typed) queued_results.push_back(fixed);
    else foreach (step_results[i]) queued_results.push_back(step_results[i]);
  endtask

  // Drain everything owed, then give the block a few spare cycles
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (queued_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [BW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    m_bpf = v;
    n_cfg++;
  endtask

  // Write burst of len declared frames sent as beats items
  task automatic burst(input int unsigned len, input int unsigned beats, input bit side);
    stim_t it;
    for (int unsigned b = 0; b < beats; b++) begin
      if (side && b > 0 && $urandom_range(15) == 0) begin
        it = rand_stim($urandom_range(1) ? KIND_READ : KIND_CLEAR);
        it.count = NW'($urandom_range(6));
        send(it);
      end
      it = rand_stim(KIND_WRITE);
      if (b == 0) it.count = NW'(len);
      it.last = (b == beats - 1);
      send(it);
    end
  endtask

  task automatic close_burst();
    stim_t it;
    if (m_open) begin
      it = rand_stim(KIND_WRITE);
      it.last = 1'b1;
      send(it);
    end
  endtask

  task automatic random_op();
    stim_t it;
    int unsigned r, len, eff, beats;
    r = $urandom_range(99);
    if (r < 45) begin
      // mostly short bursts, now and then long, short-closed or over-long
      len = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(8);
      eff = (len > MAX_REQ) ? MAX_REQ : len;
      case ($urandom_range(9))
        0: beats = eff + $urandom_range(3, 1);
        1: beats = (eff > 1) ? $urandom_range(eff - 1, 1) : 1;
        default: beats = (eff == 0) ? 1 : eff;
      endcase
      burst(len, beats, 1'b1);
    end else if (r < 75) begin
      it = rand_stim(KIND_READ);
      it.count = ($urandom_range(7) == 0) ? NW'($urandom_range(127))
                                          : NW'($urandom_range(12));
      it.chk = ($urandom_range(3) == 0);
      if ($urandom_range(1)) it.tag = m_gen;
      send(it);
    end else if (r < 82) begin
      send(rand_stim(KIND_CLEAR));
    end else if (r < 87) begin
      send(rand_stim(KIND_RSTCNT));
    end else begin
      send(rand_stim(kind_t'($urandom_range(3))));
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] e, input logic [63:0] a);
    if (a !== e) begin
      n_err++;
      if (n_err <= 100)
        $display("%0t result %0d %s: expected %0h actual %0h", $time, n_out, name, e, a);
    end
  endtask

  // Receiver stalls
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Result checker
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_out++;
      if (queued_results.size() == 0) begin
        n_err++;
        $display("%0t result %0d: expected none actual frame %0h last %0b", $time, n_out,
                 out_ch.out_frame, out_ch.last);
      end else begin
        want = queued_results.pop_front();
        check_field("out_frame", want.frame, out_ch.out_frame);
        check_field("frame_silent", 64'(want.silent), 64'(out_ch.frame_silent));
        check_field("last", 64'(want.last), 64'(out_ch.last));
        check_field("write_accepted", 64'(want.acc), 64'(out_ch.write_accepted));
        check_field("copied_frames", 64'(want.copied), 64'(out_ch.copied_frames));
        check_field("silence_frames", 64'(want.silence), 64'(out_ch.silence_frames));
        check_field("available_frames", 64'(want.avail), 64'(out_ch.available_frames));
        check_field("current_generation", 64'(want.gen), 64'(out_ch.current_generation));
        check_field("counter_value", 64'(want.cval), 64'(out_ch.counter_value));
      end
    end
  end

  // Watchdog on cycles with no item moving either way
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("pcm_frame_fifo_underrun_fill verification failed");
      $finish;
    end
  end

  // Stimulus
  initial begin
    logic [BW-1:0] sizes [6];
    int unsigned   mark;
    sizes = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd4, 4'd0};
    in_ch.valid            <= 1'b0;
    in_ch.kind             <= KIND_WRITE;
    in_ch.in_frame         <= '0;
    in_ch.frame_count      <= '0;
    in_ch.burst_last       <= 1'b0;
    in_ch.check_generation <= 1'b0;
    in_ch.generation_tag   <= '0;
    in_ch.counter_select   <= '0;
    cfg_we                 <= 1'b0;
    cfg_wdata              <= '0;
    rst_n                  <= 1'b0;
    foreach (m_cnt[i]) m_cnt[i] = '0;
    build_table();
    set_mode(0);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (dir_tab[i]) begin
      if (dir_tab[i].cfg >= 0) begin
        settle();
        write_cfg(BW'(dir_tab[i].cfg));
      end
      send(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].res);
    end

    // random phases, one frame size and idle mix each
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      write_cfg((ph == 5) ? BW'($urandom_range(15)) : sizes[ph]);
      set_mode(ph % 4);
      mark = n_in;
      while (n_in - mark < 10) random_op();
      close_burst();
    end

    settle();
    repeat (8) @(posedge clk);
    $display("Covered %0d items in, %0d results out, %0d frame-size writes",
             n_in, n_out, n_cfg);
    $display("with dropped bursts, seeks, stale reads and mixed idle and stall patterns");
    if (n_err == 0) begin
      $display("pcm_frame_fifo_underrun_fill verification clean");
    end else begin
      $display("pcm_frame_fifo_underrun_fill verification failed");
    end
    $finish;
  end

endmodule
